// ===== hw/rtl/spq_pkg.sv =====
`timescale 1ns / 1ps

package spq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int VALUE_W       = 32;
    localparam int PRIO_W        = 8;
    localparam int OCC_W         = 5;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } spq_status_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]         prio;
    } spq_entry_t;

    // Broadcast from the controller to every slot of the chain.
    typedef struct packed {
        logic       en;
        logic       op;
        spq_entry_t ent;
    } spq_cmd_t;

endpackage

// ===== hw/rtl/spq_if.sv =====
`timescale 1ns / 1ps

interface spq_req_if
    import spq_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic signed [VALUE_W-1:0] item_value;
    logic [PRIO_W-1:0]         item_priority;

    modport source (output valid, req_type, item_value, item_priority, input ready);
    modport sink   (input valid, req_type, item_value, item_priority, output ready);
endinterface

interface spq_rsp_if
    import spq_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [1:0]                status;
    logic signed [VALUE_W-1:0] removed_value;
    logic [PRIO_W-1:0]         removed_priority;
    logic [OCC_W-1:0]          occupancy;

    modport source (output valid, status, removed_value, removed_priority, occupancy,
                    input ready);
    modport sink   (input valid, status, removed_value, removed_priority, occupancy,
                    output ready);
endinterface

// ===== hw/rtl/sorted_priority_queue.sv =====
`timescale 1ns / 1ps

// Channel  Modport           Carries
// req      spq_req_if.sink   req_type, item_value, item_priority
// rsp      spq_rsp_if.source status, removed_value, removed_priority, occupancy
//
// The slot chain shifts in a single step and the response is registered, so a new
// request is accepted every cycle while rsp is taken.
// Reset empties the queue at once; slot contents are left as they are.
// A stalled response holds rsp and blocks req until it is taken.

module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    spq_cmd_t          cmd;
    spq_entry_t        ent_w   [DEPTH];
    logic [DEPTH-1:0]  valid_w;
    logic [DEPTH-1:0]  keep_w;

    logic              accept;
    logic              full;
    logic              empty;
    logic              do_insert;
    logic              do_remove;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    spq_status_t       status_reg;
    spq_status_t       status_next;
    spq_entry_t        head_reg;
    spq_entry_t        head_next;
    logic [OCC_W-1:0]  occ_reg;
    logic [OCC_W-1:0]  occ_next;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign full      = valid_w[DEPTH-1];
    assign empty     = !valid_w[0];
    assign do_insert = accept && (req.req_type == REQ_INSERT) && !full;
    assign do_remove = accept && (req.req_type == REQ_REMOVE) && !empty;

    assign cmd.en        = do_insert || do_remove;
    assign cmd.op        = req.req_type;
    assign cmd.ent.value = req.item_value;
    assign cmd.ent.prio  = req.item_priority;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_slot
        spq_entry_t l_ent;
        logic       l_valid;
        logic       l_keep;
        spq_entry_t r_ent;
        logic       r_valid;

        if (i == 0)
        begin : g_first
            assign l_ent   = cmd.ent;
            assign l_valid = 1'b1;
            assign l_keep  = 1'b1;
        end
        else
        begin : g_mid_l
            assign l_ent   = ent_w[i-1];
            assign l_valid = valid_w[i-1];
            assign l_keep  = keep_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign r_ent   = ent_w[i];
            assign r_valid = 1'b0;
        end
        else
        begin : g_mid_r
            assign r_ent   = ent_w[i+1];
            assign r_valid = valid_w[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .left_ent    (l_ent),
            .left_valid  (l_valid),
            .left_keep   (l_keep),
            .right_ent   (r_ent),
            .right_valid (r_valid),
            .ent         (ent_w[i]),
            .valid       (valid_w[i]),
            .keep        (keep_w[i])
        );
    end

    always_comb
    begin
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg;
        status_next    = status_reg;
        head_next      = head_reg;
        occ_next       = occ_reg;
        if (do_insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_remove)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (accept)
        begin
            rsp_valid_next  = 1'b1;
            occ_next        = OCC_W'(count_next);
            head_next.value = '0;
            head_next.prio  = '0;
            status_next     = ST_OK;
            if (req.req_type == REQ_INSERT)
            begin
                if (full)
                begin
                    status_next = ST_OVERFLOW;
                end
            end
            else if (empty)
            begin
                status_next = ST_UNDERFLOW;
            end
            else
            begin
                head_next = ent_w[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        head_reg   <= head_next;
        occ_reg    <= occ_next;
    end

    assign rsp.valid            = rsp_valid_reg;
    assign rsp.status           = status_reg;
    assign rsp.removed_value    = head_reg.value;
    assign rsp.removed_priority = head_reg.prio;
    assign rsp.occupancy        = occ_reg;

    // The occupied slots always form an unbroken run from the head.
    a_valid_run: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_w & (valid_w + DEPTH'(1))) == '0)
        else $error("occupied slots are not contiguous from the head");

    a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_w) == int'(count_reg))
        else $error("entry count disagrees with occupied slots");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds queue depth");

    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid_reg)
        else $error("accepted transaction produced no response");

endmodule

// ===== hw/rtl/spq_cell.sv =====
`timescale 1ns / 1ps

module spq_cell
    import spq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  spq_cmd_t   cmd,
    input  spq_entry_t left_ent,
    input  logic       left_valid,
    input  logic       left_keep,
    input  spq_entry_t right_ent,
    input  logic       right_valid,
    output spq_entry_t ent,
    output logic       valid,
    output logic       keep
);

    spq_entry_t ent_reg;
    spq_entry_t ent_next;
    logic       valid_reg;
    logic       valid_next;

    // A slot keeps its entry on insert when it ranks the same or ahead of the new one.
    assign keep = valid_reg && (ent_reg.prio <= cmd.ent.prio);

    always_comb
    begin
        ent_next   = ent_reg;
        valid_next = valid_reg;
        if (cmd.en)
        begin
            if (cmd.op == REQ_INSERT)
            begin
                if (!keep)
                begin
                    ent_next = left_keep ? cmd.ent : left_ent;
                end
                valid_next = valid_reg | left_valid;
            end
            else
            begin
                ent_next   = right_ent;
                valid_next = right_valid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    assign ent   = ent_reg;
    assign valid = valid_reg;

endmodule

// ===== verif/sorted_priority_queue_tb.sv =====
`timescale 1ns / 1ps

module sorted_priority_queue_tb
    import spq_pkg::*;
;

    localparam int Q_DEPTH        = DEPTH_DEFAULT;
    localparam int CLK_PERIOD     = 12;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int TIMEOUT_CYCLES = 400000;

    typedef struct {
        logic                      op;
        logic signed [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]         prio;
    } spq_req_t;

    typedef struct {
        spq_status_t               status;
        logic signed [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]         prio;
        logic [OCC_W-1:0]          occ;
    } spq_result_t;

    logic clk;
    logic rst_n;

    spq_req_if req_ch ();
    spq_rsp_if rsp_ch ();

    sorted_priority_queue #(
        .DEPTH (Q_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    logic signed [VALUE_W-1:0] q_value [Q_DEPTH];
    logic [PRIO_W-1:0]         q_prio  [Q_DEPTH];
    int                        q_count;

    spq_req_t    pending_reqs [$];
    spq_result_t expected_rsps [$];

    spq_req_t    in_flight;
    spq_result_t next_rsp;
    spq_result_t want;

    int tx_idle_pct;
    int rx_idle_pct;
    int rx_hold_reqs;
    int rx_hold_seen;
    int rx_hold_left;

    int n_errors;
    int n_checked;
    int n_inserted;
    int n_removed;
    int n_overflow;
    int n_underflow;
    int max_fill;

    function automatic spq_result_t predict_queue_op(input spq_req_t r);
        spq_result_t res;
        int          pos;
        res.status = ST_OK;
        res.value  = '0;
        res.prio   = '0;
        if (r.op == REQ_INSERT)
        begin
            if (q_count >= Q_DEPTH)
            begin
                res.status = ST_OVERFLOW;
            end
            else
            begin
                pos = 0;
                while (pos < q_count && q_prio[pos] <= r.prio)
                    pos++;
                for (int i = q_count; i > pos; i--)
                begin
                    q_value[i] = q_value[i-1];
                    q_prio[i]  = q_prio[i-1];
                end
                q_value[pos] = r.value;
                q_prio[pos]  = r.prio;
                q_count++;
            end
        end
        else if (q_count == 0)
        begin
            res.status = ST_UNDERFLOW;
        end
        else
        begin
            res.value = q_value[0];
            res.prio  = q_prio[0];
            for (int i = 1; i < q_count; i++)
            begin
                q_value[i-1] = q_value[i];
                q_prio[i-1]  = q_prio[i];
            end
            q_count--;
        end
        res.occ = OCC_W'(q_count);
        return res;
    endfunction

    task automatic push_req(input logic op, input logic signed [VALUE_W-1:0] value,
                            input logic [PRIO_W-1:0] prio);
        spq_req_t r;
        r.op    = op;
        r.value = value;
        r.prio  = prio;
        pending_reqs.push_back(r);
    endtask

    task automatic queue_random_reqs(input int n);
        int       ins_pct;
        int       prio_mode;
        spq_req_t r;
        ins_pct   = 50;
        prio_mode = 0;
        for (int i = 0; i < n; i++)
        begin
            if (i % 40 == 0)
            begin
                case ($urandom_range(2))
                    0:       ins_pct = 25;
                    1:       ins_pct = 50;
                    default: ins_pct = 80;
                endcase
                prio_mode = $urandom_range(3);
            end
            r.op = ($urandom_range(99) < ins_pct) ? REQ_INSERT : REQ_REMOVE;
            case (prio_mode)
                0:       r.prio = PRIO_W'($urandom);
                1:       r.prio = PRIO_W'($urandom_range(3));
                2:       r.prio = $urandom_range(1) ? 8'hFF : 8'h00;
                default: r.prio = 8'hF0 | PRIO_W'($urandom_range(15));
            endcase
            case ($urandom_range(11))
                0:       r.value = 32'sh7FFF_FFFF;
                1:       r.value = 32'sh8000_0000;
                2:       r.value = -32'sd1;
                default: r.value = $urandom;
            endcase
            pending_reqs.push_back(r);
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || req_ch.valid || expected_rsps.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever
            #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid         <= 1'b0;
            req_ch.req_type      <= REQ_INSERT;
            req_ch.item_value    <= '0;
            req_ch.item_priority <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                next_rsp = predict_queue_op(in_flight);
                expected_rsps.push_back(next_rsp);
                if (next_rsp.status == ST_OVERFLOW)
                    n_overflow++;
                else if (next_rsp.status == ST_UNDERFLOW)
                    n_underflow++;
                else if (in_flight.op == REQ_INSERT)
                    n_inserted++;
                else
                    n_removed++;
                if (q_count > max_fill)
                    max_fill = q_count;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    in_flight = pending_reqs.pop_front();
                    req_ch.valid         <= 1'b1;
                    req_ch.req_type      <= in_flight.op;
                    req_ch.item_value    <= in_flight.value;
                    req_ch.item_priority <= in_flight.prio;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            rx_hold_seen = 0;
            rx_hold_left = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                n_checked++;
                if (expected_rsps.size() == 0)
                begin
                    $display("%0t: unexpected transaction: status %0d value %0d prio %0d occ %0d",
                             $time, rsp_ch.status, rsp_ch.removed_value,
                             rsp_ch.removed_priority, rsp_ch.occupancy);
                    n_errors++;
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp_ch.status !== want.status
                        || rsp_ch.removed_value !== want.value
                        || rsp_ch.removed_priority !== want.prio
                        || rsp_ch.occupancy !== want.occ)
                    begin
                        $display("%0t: mismatch: expected status %0d value %0d prio %0d occ %0d",
                                 $time, want.status, want.value, want.prio, want.occ);
                        $display("%0t:           actual status %0d value %0d prio %0d occ %0d",
                                 $time, rsp_ch.status, rsp_ch.removed_value,
                                 rsp_ch.removed_priority, rsp_ch.occupancy);
                        n_errors++;
                    end
                end
            end
            if (rx_hold_seen != rx_hold_reqs)
            begin
                rx_hold_seen = rx_hold_reqs;
                rx_hold_left = RX_HOLD_CYCLES;
            end
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial
    begin
        logic [PRIO_W-1:0] fill_prio [16];
        fill_prio = '{8'd0, 8'd255, 8'd255, 8'd128, 8'd0, 8'd128, 8'd255, 8'd7,
                      8'd0, 8'd1, 8'd254, 8'd128, 8'd7, 8'd0, 8'd255, 8'd1};
        q_count      = 0;
        tx_idle_pct  = 29;
        rx_idle_pct  = 87;
        rx_hold_reqs = 0;
        n_errors     = 0;
        n_checked    = 0;
        n_inserted   = 0;
        n_removed    = 0;
        n_overflow   = 0;
        n_underflow  = 0;
        max_fill     = 0;
        wait (rst_n === 1'b1);

        push_req(REQ_REMOVE, 32'sh7FFF_FFFF, 8'hFF);
        for (int k = 0; k < Q_DEPTH; k++)
        begin
            if (k == 0)
                push_req(REQ_INSERT, 32'sh7FFF_FFFF, fill_prio[k % 16]);
            else if (k == 1)
                push_req(REQ_INSERT, 32'sh8000_0000, fill_prio[k % 16]);
            else
                push_req(REQ_INSERT, k * 32'sh1111_1111, fill_prio[k % 16]);
        end
        push_req(REQ_INSERT, -32'sd1, 8'h00);
        push_req(REQ_REMOVE, 32'sh8000_0000, 8'h00);
        for (int k = 0; k < 4; k++)
            push_req(REQ_REMOVE, -32'sd1, 8'hFF);
        queue_random_reqs(440);
        wait_drained();

        tx_idle_pct = 87;
        rx_idle_pct = 29;
        queue_random_reqs(460);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_reqs++;
        queue_random_reqs(480);
        wait_drained();

        repeat (10) @(posedge clk);
        $display("Checked %0d transactions: %0d inserts, %0d removals,",
                 n_checked, n_inserted, n_removed);
        $display("%0d overflows and %0d underflows.", n_overflow, n_underflow);
        $display("Queue reached %0d of %0d entries; response stall and drained pauses exercised.",
                 max_fill, Q_DEPTH);
        if (n_errors == 0)
            $display("sorted_priority_queue_tb passed");
        else
            $display("sorted_priority_queue_tb failed");
        $finish;
    end

    initial
    begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("Timed out with %0d transactions still expected.", expected_rsps.size());
        $display("sorted_priority_queue_tb failed");
        $finish;
    end

endmodule
